// ===== src/adsr_pkg.sv =====
// Shared types and constants for the ADSR envelope generator.
`default_nettype none

package adsr_pkg;

    // Fixed-point formats
    localparam int PROGRESS_FRACTION_BITS_DEF = 24;
    localparam int LEVEL_FRACTION_BITS_DEF    = 16;

    // Stage codes
    localparam int STAGE_W = 3;
    typedef enum logic [STAGE_W-1:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } stage_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK_RATE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_RATE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUSTAIN_LEVEL = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_RATE  = 2'd3;

    // Register reset values
    localparam int ATTACK_RATE_RST   = 35000;
    localparam int DECAY_RATE_RST    = 1000;
    localparam int SUSTAIN_LEVEL_RST = 45875;
    localparam int RELEASE_RATE_RST  = 1400;

    // Note counter
    localparam int NOTES_W = 2;

endpackage

`default_nettype wire

// ===== src/adsr_cfg.sv =====
// Configuration register bank of the ADSR envelope generator.
`default_nettype none

module adsr_cfg #(
    parameter int PROGRESS_FRACTION_BITS = adsr_pkg::PROGRESS_FRACTION_BITS_DEF,
    parameter int LEVEL_FRACTION_BITS    = adsr_pkg::LEVEL_FRACTION_BITS_DEF,
    parameter int PW = PROGRESS_FRACTION_BITS + 1,
    parameter int LW = LEVEL_FRACTION_BITS + 1,
    parameter int DW = (PW > LW) ? PW : LW
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [adsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [DW-1:0]                  cfg_wdata,
    output logic      [PW-1:0]                  attack_rate,
    output logic      [PW-1:0]                  decay_rate,
    output logic      [LW-1:0]                  sustain_level,
    output logic      [PW-1:0]                  release_rate
);
    import adsr_pkg::*;

    logic [PW-1:0] attack_rate_reg;
    logic [PW-1:0] decay_rate_reg;
    logic [LW-1:0] sustain_level_reg;
    logic [PW-1:0] release_rate_reg;

    // Register writes, decoded by index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_rate_reg   <= PW'(ATTACK_RATE_RST);
            decay_rate_reg    <= PW'(DECAY_RATE_RST);
            sustain_level_reg <= LW'(SUSTAIN_LEVEL_RST);
            release_rate_reg  <= PW'(RELEASE_RATE_RST);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ATTACK_RATE:   attack_rate_reg   <= cfg_wdata[PW-1:0];
                CFG_DECAY_RATE:    decay_rate_reg    <= cfg_wdata[PW-1:0];
                CFG_SUSTAIN_LEVEL: sustain_level_reg <= cfg_wdata[LW-1:0];
                CFG_RELEASE_RATE:  release_rate_reg  <= cfg_wdata[PW-1:0];
                default: ;
            endcase
        end
    end

    assign attack_rate   = attack_rate_reg;
    assign decay_rate    = decay_rate_reg;
    assign sustain_level = sustain_level_reg;
    assign release_rate  = release_rate_reg;

endmodule

`default_nettype wire

// ===== src/adsr_core.sv =====
// Envelope state and per-tick level update of the ADSR envelope generator.
`default_nettype none

module adsr_core #(
    parameter int PROGRESS_FRACTION_BITS = adsr_pkg::PROGRESS_FRACTION_BITS_DEF,
    parameter int LEVEL_FRACTION_BITS    = adsr_pkg::LEVEL_FRACTION_BITS_DEF,
    parameter int PW = PROGRESS_FRACTION_BITS + 1,
    parameter int LW = LEVEL_FRACTION_BITS + 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          item_accept,
    input  wire logic                          gate_level,
    input  wire logic [PW-1:0]                 attack_rate,
    input  wire logic [PW-1:0]                 decay_rate,
    input  wire logic [LW-1:0]                 sustain_level,
    input  wire logic [PW-1:0]                 release_rate,
    output logic      [LW-1:0]                 level_out,
    output logic      [adsr_pkg::STAGE_W-1:0]  stage_out
);
    import adsr_pkg::*;

    localparam logic [PW-1:0] PROG_ONE  = {1'b1, {PROGRESS_FRACTION_BITS{1'b0}}};
    localparam logic [LW-1:0] LEVEL_ONE = {1'b1, {LEVEL_FRACTION_BITS{1'b0}}};

    // Envelope state
    logic               prev_gate_reg, prev_gate_next;
    logic [NOTES_W-1:0] notes_held_reg, notes_held_next;
    stage_t             stage_reg, stage_next;
    logic [PW-1:0]      progress_reg, progress_next;
    logic [LW-1:0]      level_reg, level_next;
    logic [LW-1:0]      capture_reg, capture_next;

    // Intermediate values
    logic               rise, fall;
    logic [NOTES_W-1:0] notes_dec;
    stage_t             stage_edge;
    logic [PW-1:0]      progress_edge;
    logic [PW-1:0]      rate_sel;
    logic [PW:0]        progress_sum;
    logic [PW-1:0]      progress_sat;
    logic [LW-1:0]      sustain_sat;
    logic [LW-1:0]      mul_a;
    logic [PW-1:0]      mul_b;
    logic [LW+PW-1:0]   product;
    logic [LW-1:0]      scaled;

    assign rise      = gate_level & ~prev_gate_reg;
    assign fall      = ~gate_level & prev_gate_reg;
    assign notes_dec = (notes_held_reg != '0) ? notes_held_reg - 1'b1 : notes_held_reg;
    assign sustain_sat = (sustain_level > LEVEL_ONE) ? LEVEL_ONE : sustain_level;

    // Gate edges: note count, attack restart, release capture
    always_comb begin
        stage_edge      = stage_reg;
        progress_edge   = progress_reg;
        notes_held_next = notes_held_reg;
        capture_next    = capture_reg;
        if (rise) begin
            if (notes_held_reg == '0) begin
                stage_edge    = ST_ATTACK;
                progress_edge = '0;
            end
            if (notes_held_reg != {NOTES_W{1'b1}}) begin
                notes_held_next = notes_held_reg + 1'b1;
            end
        end else if (fall) begin
            notes_held_next = notes_dec;
            if (notes_dec == '0 && (stage_reg == ST_ATTACK || stage_reg == ST_DECAY ||
                                    stage_reg == ST_SUSTAIN)) begin
                stage_edge    = ST_RELEASE;
                capture_next  = level_reg;
                progress_edge = '0;
            end
        end
    end

    // Progress step with a zero rate acting as one, saturating at one
    always_comb begin
        case (stage_edge)
            ST_ATTACK:  rate_sel = attack_rate;
            ST_DECAY:   rate_sel = decay_rate;
            ST_RELEASE: rate_sel = release_rate;
            default:    rate_sel = PW'(1);
        endcase
        if (rate_sel == '0) begin
            rate_sel = PW'(1);
        end
    end

    assign progress_sum = {1'b0, progress_edge} + {1'b0, rate_sel};
    assign progress_sat = (progress_sum > {1'b0, PROG_ONE}) ? PROG_ONE : progress_sum[PW-1:0];

    // One shared multiplier: attack ramps up, decay and release scale a span
    always_comb begin
        case (stage_edge)
            ST_DECAY: begin
                mul_a = LEVEL_ONE - sustain_sat;
                mul_b = progress_sat;
            end
            ST_RELEASE: begin
                mul_a = capture_next;
                mul_b = PROG_ONE - progress_sat;
            end
            default: begin
                mul_a = LEVEL_ONE;
                mul_b = progress_sat;
            end
        endcase
    end

    assign product = {{PW{1'b0}}, mul_a} * {{LW{1'b0}}, mul_b};
    assign scaled  = product[PROGRESS_FRACTION_BITS +: LW];

    // Stage update and new level
    always_comb begin
        stage_next     = stage_edge;
        progress_next  = progress_sat;
        level_next     = '0;
        prev_gate_next = gate_level;
        case (stage_edge)
            ST_ATTACK: begin
                if (progress_sat == PROG_ONE) begin
                    level_next    = LEVEL_ONE;
                    stage_next    = ST_DECAY;
                    progress_next = '0;
                end else begin
                    level_next = scaled;
                end
            end
            ST_DECAY: begin
                if (progress_sat == PROG_ONE) begin
                    level_next    = sustain_sat;
                    stage_next    = ST_SUSTAIN;
                    progress_next = '0;
                end else begin
                    level_next = LEVEL_ONE - scaled;
                end
            end
            ST_SUSTAIN: begin
                level_next = sustain_sat;
            end
            ST_RELEASE: begin
                if (progress_sat == PROG_ONE) begin
                    stage_next = ST_IDLE;
                end else begin
                    level_next = scaled;
                end
            end
            default: begin
                stage_next = ST_IDLE;
            end
        endcase
    end

    // State registers, advanced once per accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_gate_reg  <= 1'b0;
            notes_held_reg <= '0;
            stage_reg      <= ST_IDLE;
            progress_reg   <= '0;
            level_reg      <= '0;
            capture_reg    <= '0;
        end else if (item_accept) begin
            prev_gate_reg  <= prev_gate_next;
            notes_held_reg <= notes_held_next;
            stage_reg      <= stage_next;
            progress_reg   <= progress_next;
            level_reg      <= level_next;
            capture_reg    <= capture_next;
        end
    end

    assign level_out = level_next;
    assign stage_out = stage_next;

`ifndef NO_ASSERTIONS
    // With a single gate the note count tracks the gate exactly
    a_notes_track_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        notes_held_reg == {{(NOTES_W-1){1'b0}}, prev_gate_reg})
        else $error("note count out of step with gate");

    // No note held means the envelope is idle or releasing
    a_no_note_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        notes_held_reg == '0 |-> (stage_reg == ST_IDLE || stage_reg == ST_RELEASE))
        else $error("envelope active with no note held");

    // Level never exceeds full scale, progress never exceeds one
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LEVEL_ONE && progress_reg <= PROG_ONE)
        else $error("level or progress out of range");
`endif

endmodule

`default_nettype wire

// ===== src/adsr_skid.sv =====
// Output register with a skid stage for the result channel.
`default_nettype none

module adsr_skid #(
    parameter int W = 20
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    input  wire logic [W-1:0] in_data,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic      [W-1:0] out_data
);
    logic         out_valid_reg;
    logic [W-1:0] out_data_reg;
    logic         skid_valid_reg;
    logic [W-1:0] skid_data_reg;

    // Main register refills from skid first, then from the input
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid) begin
            skid_data_reg <= in_data;
        end
    end

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // Skid only fills behind a held result
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid full while output empty");

    // Upstream never pushes into a full skid
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        !(skid_valid_reg && in_valid))
        else $error("item pushed into full skid");

    // A drained skid item becomes the next output
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && out_ready |=> out_valid_reg && out_data_reg == $past(skid_data_reg))
        else $error("skid item lost on drain");
`endif

endmodule

`default_nettype wire

// ===== src/adsr_envelope_generator.sv =====
// Top level of the linear ADSR envelope generator.
//
// Usage: one gate sample per audio tick enters on s_valid/s_ready with
// s_gate_level (1 = key held). Each accepted item yields exactly one result
// on m_valid/m_ready: m_envelope_level (full scale = 2^LEVEL_FRACTION_BITS)
// and m_stage (0 idle, 1 attack, 2 decay, 3 sustain, 4 release).
// Each result is registered before m_valid; throughput is one item per
// cycle while m_ready is high, set by the combinational update in the core
// (one shared multiplier) feeding the output register. When the receiver
// stalls, one more item is taken into a skid register, then s_ready drops
// until the output drains. State advances only on accepted items, so stalls
// never change the envelope. Reset (aresetn low, synchronous) returns the
// envelope to idle at level 0, clears the note count, empties the output
// and restores the default rates and sustain level. Registers are written
// through cfg_wr_en, cfg_index and cfg_wdata, one per cycle; the user
// writes them only while no item is in flight, not enforced by the block.
`default_nettype none

module adsr_envelope_generator #(
    parameter int PROGRESS_FRACTION_BITS = adsr_pkg::PROGRESS_FRACTION_BITS_DEF,
    parameter int LEVEL_FRACTION_BITS    = adsr_pkg::LEVEL_FRACTION_BITS_DEF,
    parameter int PW = PROGRESS_FRACTION_BITS + 1,
    parameter int LW = LEVEL_FRACTION_BITS + 1,
    parameter int DW = (PW > LW) ? PW : LW
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_gate_level,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [LW-1:0]                    m_envelope_level,
    output logic      [adsr_pkg::STAGE_W-1:0]     m_stage,
    input  wire logic                             cfg_wr_en,
    input  wire logic [adsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [DW-1:0]                    cfg_wdata
);
    import adsr_pkg::*;

    localparam int RW = LW + STAGE_W;

    logic               item_accept;
    logic [PW-1:0]      attack_rate, decay_rate, release_rate;
    logic [LW-1:0]      sustain_level;
    logic [LW-1:0]      level_out;
    logic [STAGE_W-1:0] stage_out;
    logic [RW-1:0]      result_data;

    assign item_accept = s_valid & s_ready;

    // Configuration registers
    adsr_cfg #(
        .PROGRESS_FRACTION_BITS (PROGRESS_FRACTION_BITS),
        .LEVEL_FRACTION_BITS    (LEVEL_FRACTION_BITS),
        .PW                     (PW),
        .LW                     (LW),
        .DW                     (DW)
    ) u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .attack_rate   (attack_rate),
        .decay_rate    (decay_rate),
        .sustain_level (sustain_level),
        .release_rate  (release_rate)
    );

    // Envelope state and update
    adsr_core #(
        .PROGRESS_FRACTION_BITS (PROGRESS_FRACTION_BITS),
        .LEVEL_FRACTION_BITS    (LEVEL_FRACTION_BITS),
        .PW                     (PW),
        .LW                     (LW)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_accept   (item_accept),
        .gate_level    (s_gate_level),
        .attack_rate   (attack_rate),
        .decay_rate    (decay_rate),
        .sustain_level (sustain_level),
        .release_rate  (release_rate),
        .level_out     (level_out),
        .stage_out     (stage_out)
    );

    // Result register and skid
    adsr_skid #(
        .W (RW)
    ) u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (item_accept),
        .in_data   ({level_out, stage_out}),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (result_data)
    );

    assign m_envelope_level = result_data[RW-1:STAGE_W];
    assign m_stage          = result_data[STAGE_W-1:0];

endmodule

`default_nettype wire
